@@ sv/bepa_pkg.sv @@
// bepa_pkg: shared types, constants and helpers for the button event and pot average unit
// no dependencies
`timescale 1ns / 1ps

package bepa_pkg;

   // csr map
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FILTER_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONG_PRESS_MS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MENU_GUARD_MS = 2'd2;

   localparam logic [4:0]  FILTER_LEN_4  = 5'd4;
   localparam logic [4:0]  FILTER_LEN_16 = 5'd16;
   localparam logic [2:0]  SHIFT_LEN_4   = 3'd2;
   localparam logic [2:0]  SHIFT_LEN_8   = 3'd3;
   localparam logic [2:0]  SHIFT_LEN_16  = 3'd4;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd700;
   localparam logic [15:0] MENU_GUARD_RESET = 16'd60;

   // sample ring
   localparam int RING_DEPTH = 16;
   localparam int POS_BITS   = $clog2(RING_DEPTH);
   localparam int AVG_BITS   = 10;

   // auto-repeat schedule
   localparam logic [31:0] HOLD_TIER_1 = 32'd350;
   localparam logic [31:0] HOLD_TIER_2 = 32'd900;
   localparam logic [31:0] HOLD_TIER_3 = 32'd1600;
   localparam logic [31:0] GAP_TIER_0  = 32'd180;
   localparam logic [31:0] GAP_TIER_1  = 32'd120;
   localparam logic [31:0] GAP_TIER_2  = 32'd80;
   localparam logic [31:0] GAP_TIER_3  = 32'd55;

   localparam logic signed [1:0] STEP_NONE = 2'sb00;
   localparam logic signed [1:0] STEP_UP   = 2'sb01;
   localparam logic signed [1:0] STEP_DOWN = 2'sb11;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        up_level;
      logic        down_level;
      logic        ok_level;
      logic        menu_level;
      logic [9:0]  pot_sample;
   } req_type;

   typedef struct packed {
      logic signed [1:0]   step_count;
      logic                menu_click;
      logic                ok_long;
      logic                ok_short;
      logic [AVG_BITS-1:0] pot_average;
   } rsp_type;

   typedef struct packed {
      logic       reprime;
      logic [2:0] shift;
   } pot_ctl_type;

   function automatic logic [2:0] filter_shift(input logic [4:0] len);
      logic [2:0] s;
      if (len == FILTER_LEN_4) begin
         s = SHIFT_LEN_4;
      end else if (len == FILTER_LEN_16) begin
         s = SHIFT_LEN_16;
      end else begin
         s = SHIFT_LEN_8;
      end
      return s;
   endfunction

   function automatic logic repeat_due(input logic [31:0] now, input logic [31:0] press,
                                       input logic [31:0] last);
      logic [31:0] held;
      logic [31:0] since;
      logic        due;
      held  = now - press;
      since = now - last;
      if (held < HOLD_TIER_1) begin
         due = (since >= GAP_TIER_0);
      end else if (held < HOLD_TIER_2) begin
         due = (since >= GAP_TIER_1);
      end else if (held < HOLD_TIER_3) begin
         due = (since >= GAP_TIER_2);
      end else begin
         due = (since >= GAP_TIER_3);
      end
      return due;
   endfunction

endpackage

@@ sv/bepa_pot_avg.sv @@
// bepa_pot_avg: moving average of pot samples over a ring memory with a running sum
// depends on bepa_pkg
`timescale 1ns / 1ps

module bepa_pot_avg #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [SAMPLE_BITS-1:0]          sample,
   input  bepa_pkg::pot_ctl_type           ctl,
   output logic [bepa_pkg::AVG_BITS-1:0]   average
);
   import bepa_pkg::*;

   localparam int SUM_W = SAMPLE_BITS + POS_BITS;

   logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [POS_BITS-1:0]    pos_ff, pos_in, pos_next, mask;
   logic                   primed_ff, primed_in;
   logic                   wrapped_ff, wrapped_in;
   logic [SUM_W-1:0]       sum_ff, sum_in, sum_new;
   logic [SAMPLE_BITS-1:0] prime_val_ff, prime_val_in;
   logic [SAMPLE_BITS-1:0] old_val;
   logic                   wr_en;

   always_comb begin
      mask     = POS_BITS'(({{POS_BITS{1'b0}}, 1'b1} << ctl.shift) - 1'b1);
      pos_next = (pos_ff + 1'b1) & mask;
      // entries not yet overwritten since priming still hold the priming sample
      old_val  = wrapped_ff ? rd_data_ff : prime_val_ff;
      if (primed_ff) begin
         sum_new = sum_ff - SUM_W'(old_val) + SUM_W'(sample);
      end else begin
         sum_new = SUM_W'(sample) << ctl.shift;
      end
      average = AVG_BITS'(sum_new >> ctl.shift);
   end

   always_comb begin
      pos_in       = pos_ff;
      primed_in    = primed_ff;
      wrapped_in   = wrapped_ff;
      sum_in       = sum_ff;
      prime_val_in = prime_val_ff;
      wr_en        = 1'b0;
      if (ctl.reprime) begin
         pos_in     = '0;
         primed_in  = 1'b0;
         wrapped_in = 1'b0;
      end else if (accept) begin
         sum_in = sum_new;
         if (!primed_ff) begin
            primed_in    = 1'b1;
            pos_in       = '0;
            prime_val_in = sample;
         end else begin
            wr_en      = 1'b1;
            pos_in     = pos_next;
            wrapped_in = wrapped_ff | (pos_next == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         primed_ff  <= 1'b0;
         wrapped_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         primed_ff  <= primed_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      prime_val_ff <= prime_val_in;
   end

   // prefetch the entry the next item will replace
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[pos_ff] <= sample;
      end
      rd_data_ff <= ring_mem[pos_in];
   end

`ifndef SYNTHESIS
   a_rw_apart: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (pos_in != pos_ff))
      else $error("ring read and write hit the same entry");
   a_wrap_needs_prime: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |-> primed_ff)
      else $error("ring wrapped without priming");
   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      primed_ff && !ctl.reprime |-> ((pos_ff & ~mask) == '0))
      else $error("ring position outside window");
`endif

endmodule

@@ sv/button_events_with_pot_average_unit.sv @@
// button_events_with_pot_average_unit: top level, button event logic, csr block, output skid
// depends on bepa_pkg and bepa_pot_avg
`timescale 1ns / 1ps

// One poll item is taken per clock cycle while req_stall is low; its result item goes to the
// output register, or to the skid entry while that register is full and stalled. Button
// state sits in flops; the pot window sits in a 16-entry ring memory whose entry to be
// replaced is read ahead, so back-to-back items never wait on the memory. The result side
// has an output register plus one skid entry: req_stall rises only when both are full. No
// clearing pass follows reset or a filter length write; the first sample after either
// primes the window. Configuration writes are always ready and belong in idle periods.
module button_events_with_pot_average_unit #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  bepa_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output bepa_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bepa_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [bepa_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import bepa_pkg::*;

   logic        accept, take, csr_we;
   logic [2:0]  shift_ff, shift_in;
   logic [15:0] long_press_ff, long_press_in;
   logic [15:0] menu_guard_ff, menu_guard_in;
   pot_ctl_type pot_ctl;

   logic        up_prev_ff, down_prev_ff, ok_prev_ff, menu_prev_ff;
   logic        long_fired_ff, long_fired_in;
   logic [15:0] ok_press_ff, ok_press_in;
   logic [15:0] menu_last_ff, menu_last_in;
   logic [31:0] up_press_ff, up_press_in, down_press_ff, down_press_in;
   logic [31:0] up_rep_ff, up_rep_in, down_rep_ff, down_rep_in;

   logic        up_edge, down_edge, ok_edge, menu_edge;
   logic        up_step, down_step, click, lng, shrt, lf_eff;
   logic [15:0] ok_press_eff, ok_held;
   logic [AVG_BITS-1:0]    avg;
   logic [SAMPLE_BITS-1:0] sample;
   rsp_type     rsp_new;

   rsp_type     out_data_ff, out_data_in, skid_data_ff, skid_data_in;
   logic        out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign sample    = SAMPLE_BITS'(req_data.pot_sample);

   // csr block
   always_comb begin
      shift_in       = shift_ff;
      long_press_in  = long_press_ff;
      menu_guard_in  = menu_guard_ff;
      pot_ctl.reprime = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_FILTER_LENGTH: begin
               shift_in        = filter_shift(csr_wdata[4:0]);
               pot_ctl.reprime = 1'b1;
            end
            REG_LONG_PRESS_MS: begin
               long_press_in = csr_wdata;
            end
            REG_MENU_GUARD_MS: begin
               menu_guard_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
      pot_ctl.shift = shift_ff;
   end

   // button events
   always_comb begin
      up_edge   = req_data.up_level && !up_prev_ff;
      down_edge = req_data.down_level && !down_prev_ff;
      ok_edge   = req_data.ok_level && !ok_prev_ff;
      menu_edge = req_data.menu_level && !menu_prev_ff;

      up_step   = up_edge || (req_data.up_level &&
                  repeat_due(req_data.now_ms, up_press_ff, up_rep_ff));
      down_step = down_edge || (req_data.down_level &&
                  repeat_due(req_data.now_ms, down_press_ff, down_rep_ff));

      click = menu_edge && ((req_data.now_ms[15:0] - menu_last_ff) >= menu_guard_ff);

      ok_press_eff = ok_edge ? req_data.now_ms[15:0] : ok_press_ff;
      lf_eff       = ok_edge ? 1'b0 : long_fired_ff;
      ok_held      = req_data.now_ms[15:0] - ok_press_eff;
      lng  = req_data.ok_level && !lf_eff && (ok_held >= long_press_ff);
      shrt = !req_data.ok_level && ok_prev_ff && !long_fired_ff;

      up_press_in   = up_edge ? req_data.now_ms : up_press_ff;
      down_press_in = down_edge ? req_data.now_ms : down_press_ff;
      up_rep_in     = up_step ? req_data.now_ms : up_rep_ff;
      down_rep_in   = down_step ? req_data.now_ms : down_rep_ff;
      menu_last_in  = click ? req_data.now_ms[15:0] : menu_last_ff;
      ok_press_in   = ok_press_eff;
      long_fired_in = lf_eff | lng;

      case ({up_step, down_step})
         2'b10:   rsp_new.step_count = STEP_UP;
         2'b01:   rsp_new.step_count = STEP_DOWN;
         default: rsp_new.step_count = STEP_NONE;
      endcase
      rsp_new.menu_click  = click;
      rsp_new.ok_long     = lng;
      rsp_new.ok_short    = shrt;
      rsp_new.pot_average = avg;
   end

   bepa_pot_avg #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_pot_avg (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .sample  (sample),
      .ctl     (pot_ctl),
      .average (avg)
   );

   // output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take || !out_valid_ff) begin
         out_valid_in  = skid_valid_ff || accept;
         out_data_in   = skid_valid_ff ? skid_data_ff : rsp_new;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= SHIFT_LEN_8;
         long_press_ff <= LONG_PRESS_RESET;
         menu_guard_ff <= MENU_GUARD_RESET;
         up_prev_ff    <= 1'b0;
         down_prev_ff  <= 1'b0;
         ok_prev_ff    <= 1'b0;
         menu_prev_ff  <= 1'b0;
         long_fired_ff <= 1'b0;
         ok_press_ff   <= '0;
         menu_last_ff  <= '0;
         up_press_ff   <= '0;
         down_press_ff <= '0;
         up_rep_ff     <= '0;
         down_rep_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         shift_ff      <= shift_in;
         long_press_ff <= long_press_in;
         menu_guard_ff <= menu_guard_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            up_prev_ff    <= req_data.up_level;
            down_prev_ff  <= req_data.down_level;
            ok_prev_ff    <= req_data.ok_level;
            menu_prev_ff  <= req_data.menu_level;
            long_fired_ff <= long_fired_in;
            ok_press_ff   <= ok_press_in;
            menu_last_ff  <= menu_last_in;
            up_press_ff   <= up_press_in;
            down_press_ff <= down_press_in;
            up_rep_ff     <= up_rep_in;
            down_rep_ff   <= down_rep_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output register empty");
   a_skid_fills: assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("item accepted behind a stalled result was lost");
   a_ok_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.ok_long && rsp_data.ok_short))
      else $error("ok long and ok short in one item");
   a_long_once: assert property (@(posedge clock) disable iff (reset)
      accept && long_fired_ff && !ok_edge |-> !lng)
      else $error("ok long event fired twice in one press");
`endif

endmodule

@@ bench/bepa_event_check.sv @@
// bepa_event_check: watches the poll, result and csr channels of the unit, keeps its own
// copy of the button and pot state, predicts every result item and compares field by field
// depends on bepa_pkg
`timescale 1ns / 1ps

module bepa_event_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  bepa_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  bepa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [bepa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bepa_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);
   import bepa_pkg::*;

   // predicted button state
   logic        up_was, down_was, ok_was, menu_was, long_done;
   logic [31:0] ok_since, menu_since, up_since, down_since;
   logic [31:0] up_last_step, down_last_step;

   // predicted pot window
   logic [9:0]  window [RING_DEPTH];
   logic [3:0]  slot;
   logic        window_full;
   logic [9:0]  mean;

   // register copies
   logic [4:0]  win_len;
   logic [15:0] long_ms;
   logic [15:0] guard_ms;

   rsp_type     predicted_events[$];
   rsp_type     want;
   rsp_type     got;
   int          errors = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic logic [31:0] repeat_interval(input logic [31:0] held);
      if (held < 32'd350) return 32'd180;
      if (held < 32'd900) return 32'd120;
      if (held < 32'd1600) return 32'd80;
      return 32'd55;
   endfunction

   task automatic clear_state();
      win_len = 5'd8;
      long_ms = 16'd700;
      guard_ms = 16'd60;
      {up_was, down_was, ok_was, menu_was, long_done} = '0;
      {ok_since, menu_since, up_since, down_since} = '0;
      {up_last_step, down_last_step} = '0;
      window_full = 1'b0;
      slot = '0;
      mean = '0;
   endtask

   task automatic apply_write(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         REG_FILTER_LENGTH: begin
            win_len = value[4:0];
            if (win_len != 5'd4 && win_len != 5'd16) win_len = 5'd8;
            window_full = 1'b0;
            slot = '0;
            mean = '0;
         end
         REG_LONG_PRESS_MS: long_ms = value;
         REG_MENU_GUARD_MS: guard_ms = value;
         default: ;
      endcase
   endtask

   task automatic predict_poll(input req_type r, output rsp_type e);
      int          net;
      int          total;
      int          n;
      int          i;
      int          sh;
      logic [31:0] now;
      logic [31:0] elapsed;
      now = r.now_ms;
      net = 0;
      e = '0;

      if (r.menu_level && !menu_was) begin
         elapsed = now - menu_since;
         if (elapsed[15:0] >= guard_ms) begin
            e.menu_click = 1'b1;
            menu_since = now;
         end
      end

      if (r.up_level && !up_was) begin
         net += 1;
         up_since = now;
         up_last_step = now;
      end
      if (r.down_level && !down_was) begin
         net -= 1;
         down_since = now;
         down_last_step = now;
      end
      elapsed = now - up_last_step;
      if (r.up_level && elapsed >= repeat_interval(now - up_since)) begin
         net += 1;
         up_last_step = now;
      end
      elapsed = now - down_last_step;
      if (r.down_level && elapsed >= repeat_interval(now - down_since)) begin
         net -= 1;
         down_last_step = now;
      end

      if (r.ok_level && !ok_was) begin
         ok_since = now;
         long_done = 1'b0;
      end
      elapsed = now - ok_since;
      if (r.ok_level && !long_done && elapsed[15:0] >= long_ms) begin
         e.ok_long = 1'b1;
         long_done = 1'b1;
      end
      if (!r.ok_level && ok_was && !long_done) e.ok_short = 1'b1;

      ok_was = r.ok_level;
      menu_was = r.menu_level;
      up_was = r.up_level;
      down_was = r.down_level;

      // moving mean, first sample fills the whole window
      n = int'(win_len);
      if (!window_full) begin
         for (i = 0; i < n; i++) window[i] = r.pot_sample;
         window_full = 1'b1;
         slot = '0;
         mean = r.pot_sample;
      end else begin
         window[slot] = r.pot_sample;
         slot = 4'((int'(slot) + 1) & (n - 1));
         total = 0;
         for (i = 0; i < n; i++) total += int'(window[i]);
         sh = (n == 4) ? 2 : (n == 16) ? 4 : 3;
         mean = 10'(total >> sh);
      end

      e.step_count = 2'(net);
      e.pot_average = mean;
   endtask

   task automatic compare_field(input string name, input logic signed [15:0] want_v,
                                input logic signed [15:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s mismatch, predicted %0d, got %0d", $time, name, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         predicted_events.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_events.size() == 0) begin
               errors++;
               $display("%0t: result item with none predicted, predicted nothing, got %p",
                        $time, rsp_data);
            end else begin
               want = predicted_events.pop_front();
               compare_field("step_count", 16'(want.step_count),
                             16'(rsp_data.step_count));
               compare_field("menu_click", 16'(want.menu_click),
                             16'(rsp_data.menu_click));
               compare_field("ok_long", 16'(want.ok_long), 16'(rsp_data.ok_long));
               compare_field("ok_short", 16'(want.ok_short), 16'(rsp_data.ok_short));
               compare_field("pot_average", 16'(want.pot_average),
                             16'(rsp_data.pot_average));
            end
         end
         if (csr_valid && csr_ready) apply_write(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            predict_poll(req_data, got);
            predicted_events.push_back(got);
         end
      end
      fail_count <= errors;
      pending <= predicted_events.size();
   end

endmodule

@@ bench/button_events_with_pot_average_unit_tb.sv @@
// button_events_with_pot_average_unit_tb: stimulus, csr phases and verdict for the unit
// depends on bepa_pkg, bepa_event_check and button_events_with_pot_average_unit
`timescale 1ns / 1ps

module button_events_with_pot_average_unit_tb;
   import bepa_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   int                        fail_count;
   int                        pending;

   int                        polls_sent = 0;
   int                        results_seen = 0;
   logic [31:0]               sim_ms = '0;
   logic                      up_held = 1'b0;
   logic                      down_held = 1'b0;
   logic                      ok_held = 1'b0;
   logic                      menu_held = 1'b0;

   always #1 clock = ~clock;

   button_events_with_pot_average_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bepa_event_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin : run_limit
      #1000000;
      $display("button_events_with_pot_average_unit regression: fail");
      $finish;
   end

   // result side, with long hold-offs so the unit backs up into its input
   initial begin : result_sink
      int hold;
      forever begin
         if (results_seen == 150 || results_seen == 700) hold = 40;
         else if (results_seen % 128 < 40) hold = 0;
         else hold = $urandom_range(0, 6);
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall = 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
      end
   end

   task automatic offer(input logic [31:0] t, input logic u, input logic d, input logic o,
                        input logic m, input logic [9:0] p);
      req_type item;
      int      gap;
      item.now_ms = t;
      item.up_level = u;
      item.down_level = d;
      item.ok_level = o;
      item.menu_level = m;
      item.pot_sample = p;
      gap = (polls_sent % 150 < 40) ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      do @(posedge clock); while (req_stall);
      polls_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly realistic button holds with random timing, a little noise on top
   task automatic random_polls(input int count);
      int         k;
      logic [9:0] pot;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(0, 49))
            0: sim_ms = $urandom();
            1, 2, 3, 4: sim_ms += $urandom_range(0, 2000);
            default: sim_ms += $urandom_range(0, 80);
         endcase
         if ($urandom_range(0, 49) == 0) begin
            {up_held, down_held, ok_held, menu_held} = 4'($urandom_range(0, 15));
         end else begin
            if ($urandom_range(0, 24) == 0) up_held = ~up_held;
            if ($urandom_range(0, 24) == 0) down_held = ~down_held;
            if ($urandom_range(0, 29) == 0) ok_held = ~ok_held;
            if ($urandom_range(0, 3) == 0) menu_held = ~menu_held;
         end
         case ($urandom_range(0, 19))
            0: pot = '0;
            1: pot = 10'h3FF;
            default: pot = 10'($urandom_range(0, 1023));
         endcase
         offer(sim_ms, up_held, down_held, ok_held, menu_held, pot);
      end
   endtask

   initial begin : stimulus
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // priming, guard, repeats, ok long and short, timestamp wrap
      offer(32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'h3FF);
      offer(32'd5, 1'b0, 1'b0, 1'b0, 1'b0, 10'h000);
      offer(32'd10, 1'b1, 1'b0, 1'b0, 1'b1, 10'd512);
      offer(32'd20, 1'b1, 1'b0, 1'b0, 1'b0, 10'd511);
      offer(32'd100, 1'b1, 1'b0, 1'b0, 1'b1, 10'd1);
      offer(32'd200, 1'b1, 1'b1, 1'b1, 1'b0, 10'd1022);
      offer(32'd900, 1'b1, 1'b1, 1'b1, 1'b0, 10'h155);
      offer(32'd950, 1'b0, 1'b0, 1'b0, 1'b0, 10'h2AA);
      offer(32'd1000, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0);
      offer(32'd1100, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0);
      offer(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 1'b1, 10'h3FF);
      offer(32'h0000_00A8, 1'b1, 1'b0, 1'b0, 1'b1, 10'h3FF);
      offer(32'h0000_0700, 1'b1, 1'b0, 1'b0, 1'b0, 10'h3FF);
      offer(32'h0000_0740, 1'b1, 1'b0, 1'b1, 1'b0, 10'h3FF);
      offer(32'h0000_0750, 1'b0, 1'b1, 1'b1, 1'b1, 10'h000);
      offer(32'h0001_0760, 1'b1, 1'b1, 1'b1, 1'b1, 10'h3FF);
      offer(32'h0001_0A20, 1'b1, 1'b1, 1'b1, 1'b1, 10'h200);
      offer(32'h0001_0A30, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0);
      sim_ms = 32'h0001_0A30;

      random_polls(300);
      drain();
      write_reg(REG_FILTER_LENGTH, 16'd4);
      write_reg(REG_LONG_PRESS_MS, 16'd0);
      write_reg(REG_MENU_GUARD_MS, 16'd0);
      random_polls(250);

      drain();
      write_reg(REG_FILTER_LENGTH, 16'd0);
      write_reg(REG_FILTER_LENGTH, 16'd16);
      write_reg(REG_LONG_PRESS_MS, 16'hFFFF);
      write_reg(REG_MENU_GUARD_MS, 16'hFFFF);
      sim_ms = 32'hFFFF_8000;
      random_polls(200);

      drain();
      write_reg(REG_FILTER_LENGTH, 16'd31);
      write_reg(REG_LONG_PRESS_MS, 16'd1);
      write_reg(REG_MENU_GUARD_MS, 16'd1);
      write_reg(REG_SPARE, 16'hFFFF);
      random_polls(200);

      drain();
      write_reg(REG_FILTER_LENGTH, 16'hFFE4);
      write_reg(REG_LONG_PRESS_MS, 16'd300);
      write_reg(REG_MENU_GUARD_MS, 16'd120);
      random_polls(250);

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("button_events_with_pot_average_unit regression: pass");
      end else begin
         $display("button_events_with_pot_average_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/bepa_pkg.sv
sv/bepa_pot_avg.sv
sv/button_events_with_pot_average_unit.sv
bench/bepa_event_check.sv
bench/button_events_with_pot_average_unit_tb.sv
